FILE: sv/scs_pkg.sv
// Shared types and constants for the stereo crossfade splicer.
package scs_pkg;

   localparam int SAMPLE_BITS = 16;   // Q1.15 sample width
   localparam int CFG_W       = 25;   // width of every control register
   localparam int CSR_IDX_W   = 2;    // register index width
   localparam int WEIGHT_FRAC = 16;   // Q0.16 ramp weight
   localparam int DIV_STEPS   = WEIGHT_FRAC;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPLICE_START = 2'd0,
      CSR_SPLICE_END   = 2'd1,
      CSR_FADE_LENGTH  = 2'd2,
      CSR_FRAME_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ZONE_ORIG_HEAD = 3'd0,
      ZONE_FADE_IN   = 3'd1,
      ZONE_GENERATED = 3'd2,
      ZONE_FADE_OUT  = 3'd3,
      ZONE_ORIG_TAIL = 3'd4,
      ZONE_BEYOND    = 3'd5
   } zone_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CLASSIFY,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                          first_frame;
      logic signed [SAMPLE_BITS-1:0] new_left;
      logic signed [SAMPLE_BITS-1:0] new_right;
      logic signed [SAMPLE_BITS-1:0] orig_left;
      logic signed [SAMPLE_BITS-1:0] orig_right;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mix_left;
      logic signed [SAMPLE_BITS-1:0] mix_right;
      logic [2:0]                    zone;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // capture input transfer, advance frame position
      logic prep;       // register clamped window bounds
      logic classify;   // register zone, load divider
      logic div_step;   // one restoring-division step
      logic mul;        // register the two weighted products
      logic out_load;   // load output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_div;  // current frame lies in a fade zone
   } dp_status_type;

endpackage

FILE: sv/stereo_crossfade_splicer_top.sv
// Top level of the stereo crossfade splicer: controller plus datapath.
//
//  channel  | handshake           | payload                                   | dir
//  ---------+---------------------+-------------------------------------------+-----
//  req_     | req_valid/req_stall | req_data: first_frame, new/orig L and R   | in
//  rsp_     | rsp_valid/rsp_stall | rsp_data: mix_left, mix_right, zone       | out
//  csr_     | csr_wr_en           | csr_index, csr_wdata (25 bits)            | in
//
// One frame at a time. Frames outside a crossfade skip the divider; frames inside
// a fade also pass through the 16-step restoring divider that forms the Q0.16
// ramp weight.
// Reset is synchronous; it clears the control registers, frame position and
// the controller. A finished result sits in the output register, so a new
// frame is taken while rsp_stall holds the previous one.
module stereo_crossfade_splicer_top #(
   parameter longint unsigned MAX_FRAMES = 64'd16777216   // frame position saturates here
) (
   input  logic                          clock,
   input  logic                          reset,
   // control register writes
   input  logic                          csr_wr_en,
   input  logic [scs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scs_pkg::CFG_W-1:0]     csr_wdata,
   // frame input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  scs_pkg::req_data_type         req_data,
   // spliced output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output scs_pkg::rsp_data_type         rsp_data
);
   import scs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer: idle -> window bounds -> zone -> divide (fades only)
   // -> multiply -> output load.
   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, frame counter, window math, divider and mixer.
   scs_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: sv/scs_ctrl.sv
// Controller state machine for the stereo crossfade splicer.
module scs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  scs_pkg::dp_status_type status,
   output scs_pkg::ctrl_cmd_type  cmd
);
   import scs_pkg::*;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_PREP;
         ST_PREP:     state_in = ST_CLASSIFY;
         ST_CLASSIFY: state_in = status.needs_div ? ST_DIV : ST_MUL;
         ST_DIV:      if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_MUL;
         ST_MUL:      state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_PREP:     cmd.prep     = 1'b1;
         ST_CLASSIFY: cmd.classify = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_MUL:      cmd.mul      = 1'b1;
         ST_DONE:     cmd.out_load = out_free;
         default:     cmd          = '0;
      endcase
   end

   always_comb begin
      step_in = '0;
      if (state_ff == ST_DIV) step_in = step_ff + STEP_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall)     rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/scs_datapath.sv
// Datapath: control registers, frame counter, window math, ramp divider, mixer.
module scs_datapath #(
   parameter longint unsigned MAX_FRAMES = 64'd16777216
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [scs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scs_pkg::CFG_W-1:0]           csr_wdata,
   input  scs_pkg::req_data_type               req_data,
   output scs_pkg::rsp_data_type               rsp_data,
   input  scs_pkg::ctrl_cmd_type               cmd,
   output scs_pkg::dp_status_type              status
);
   import scs_pkg::*;

   localparam int POS_W  = $clog2(MAX_FRAMES + 64'd1);
   localparam int CMP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;
   localparam int SB     = SAMPLE_BITS;
   localparam int WF     = WEIGHT_FRAC;
   localparam int PROD_W = SB + WF + 2;
   localparam int ACC_W  = SB + WF + 3;

   // control registers
   logic [CFG_W-1:0] start_cfg_ff, end_cfg_ff, fade_cfg_ff, count_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_cfg_ff <= '0;
         end_cfg_ff   <= '0;
         fade_cfg_ff  <= '0;
         count_cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPLICE_START: start_cfg_ff <= csr_wdata;
            CSR_SPLICE_END:   end_cfg_ff   <= csr_wdata;
            CSR_FADE_LENGTH:  fade_cfg_ff  <= csr_wdata;
            CSR_FRAME_COUNT:  count_cfg_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // frame position and captured item
   logic [POS_W-1:0] frame_pos_ff, frame_pos_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   req_data_type     item_ff;

   assign pos_in       = req_data.first_frame ? '0 : frame_pos_ff;
   assign frame_pos_in = (64'(pos_in) < MAX_FRAMES) ? pos_in + POS_W'(1)
                                                    : POS_W'(MAX_FRAMES);

   always_ff @(posedge clock) begin
      if (reset) frame_pos_ff <= '0;
      else if (cmd.accept) frame_pos_ff <= frame_pos_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff  <= pos_in;
         item_ff <= req_data;
      end
   end

   // window bounds
   logic [CFG_W-1:0] f_c, start_c, end_raw_c, end_c, fs_c, fe_c;
   logic [CFG_W:0]   end_plus_c;
   logic [CFG_W-1:0] f_ff, start_ff, end_ff, fs_ff, fe_ff;
   logic             whole_ff;

   always_comb begin
      f_c        = (64'(count_cfg_ff) > MAX_FRAMES) ? CFG_W'(MAX_FRAMES) : count_cfg_ff;
      start_c    = (start_cfg_ff < f_c) ? start_cfg_ff : f_c;
      end_raw_c  = (end_cfg_ff < f_c) ? end_cfg_ff : f_c;
      end_c      = (end_raw_c < start_c) ? start_c : end_raw_c;
      fs_c       = start_c - ((fade_cfg_ff < start_c) ? fade_cfg_ff : start_c);
      end_plus_c = {1'b0, end_c} + {1'b0, fade_cfg_ff};
      fe_c       = (end_plus_c > {1'b0, f_c}) ? f_c : end_plus_c[CFG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         f_ff     <= f_c;
         start_ff <= start_c;
         end_ff   <= end_c;
         fs_ff    <= fs_c;
         fe_ff    <= fe_c;
         whole_ff <= (start_c == '0) && (end_c >= f_c);
      end
   end

   // zone decision and divider operands
   logic [CMP_W-1:0] pos_ext;
   logic [CFG_W-1:0] p_c;
   zone_type         zone_c, zone_ff;
   logic [CFG_W-1:0] num_c;
   logic [CFG_W:0]   den_c;

   always_comb begin
      pos_ext = CMP_W'(pos_ff);
      p_c     = CFG_W'(pos_ext);
      num_c   = '0;
      den_c   = '0;
      if (pos_ext >= CMP_W'(f_ff))  zone_c = ZONE_BEYOND;
      else if (whole_ff)            zone_c = ZONE_GENERATED;
      else if (p_c < fs_ff)         zone_c = ZONE_ORIG_HEAD;
      else if (p_c < start_ff)      zone_c = ZONE_FADE_IN;
      else if (p_c < end_ff)        zone_c = ZONE_GENERATED;
      else if (p_c < fe_ff)         zone_c = ZONE_FADE_OUT;
      else                          zone_c = ZONE_ORIG_TAIL;
      if (zone_c == ZONE_FADE_IN) begin
         num_c = p_c - fs_ff + CFG_W'(1);
         den_c = {1'b0, start_ff - fs_ff} + (CFG_W + 1)'(1);
      end else begin
         num_c = p_c - end_ff + CFG_W'(1);
         den_c = {1'b0, fe_ff - end_ff} + (CFG_W + 1)'(1);
      end
   end

   assign status.needs_div = (zone_c == ZONE_FADE_IN) || (zone_c == ZONE_FADE_OUT);

   // restoring divider: quotient = (num << WF) / den, num < den
   logic [CFG_W:0]   rem_ff, den_ff;
   logic [WF-1:0]    quo_ff;
   logic [CFG_W+1:0] rem_sh, rem_sub;
   logic             rem_ge;

   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_ge  = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         zone_ff <= zone_c;
         rem_ff  <= {1'b0, num_c};
         den_ff  <= den_c;
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[CFG_W:0] : rem_sh[CFG_W:0];
         quo_ff <= {quo_ff[WF-2:0], rem_ge};
      end
   end

   // mix = orig + (new - orig) * wn, rounded half up
   logic [WF:0]              wn;
   logic signed [SB:0]       diff_l, diff_r;
   logic signed [PROD_W-1:0] prod_l_ff, prod_r_ff;

   always_comb begin
      case (zone_ff) inside
         ZONE_ORIG_HEAD, ZONE_ORIG_TAIL: wn = '0;
         ZONE_FADE_IN:                   wn = {1'b0, quo_ff};
         ZONE_FADE_OUT:                  wn = {1'b1, {WF{1'b0}}} - {1'b0, quo_ff};
         default:                        wn = {1'b1, {WF{1'b0}}};
      endcase
   end

   assign diff_l = {item_ff.new_left[SB-1], item_ff.new_left}
                 - {item_ff.orig_left[SB-1], item_ff.orig_left};
   assign diff_r = {item_ff.new_right[SB-1], item_ff.new_right}
                 - {item_ff.orig_right[SB-1], item_ff.orig_right};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_l_ff <= diff_l * $signed({1'b0, wn});
         prod_r_ff <= diff_r * $signed({1'b0, wn});
      end
   end

   logic signed [ACC_W-1:0] acc_l, acc_r;
   logic signed [ACC_W-1:0] round_c;

   assign round_c = ACC_W'(1) <<< (WF - 1);
   assign acc_l = {{3{item_ff.orig_left[SB-1]}}, item_ff.orig_left, {WF{1'b0}}}
                + {prod_l_ff[PROD_W-1], prod_l_ff} + round_c;
   assign acc_r = {{3{item_ff.orig_right[SB-1]}}, item_ff.orig_right, {WF{1'b0}}}
                + {prod_r_ff[PROD_W-1], prod_r_ff} + round_c;

   rsp_data_type out_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.mix_left  <= acc_l[SB+WF-1:WF];
         out_ff.mix_right <= acc_r[SB+WF-1:WF];
         out_ff.zone      <= zone_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule
